[rtl/smf_pkg.sv]
// Package for the track chunk parser: item layouts, parse phases, result kinds,
// byte codes and field widths. Used by every module of the block.
package smf_pkg;

    localparam int TICK_BITS_DEF = 40;
    localparam int VLQ_BITS      = 28;
    localparam int MSG_BITS      = 24;
    localparam int SXLEN_BITS    = 29;
    localparam int CHUNK_BITS    = 32;
    localparam int IN_DATA_BITS  = 40;

    localparam logic [7:0] BYTE_LOW7   = 8'h7F;
    localparam logic [7:0] BYTE_HIGH   = 8'h80;
    localparam logic [7:0] STAT_META   = 8'hFF;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] STAT_SYSEX  = 8'hF0;
    localparam logic [7:0] STAT_ESCAPE = 8'hF7;
    localparam logic [7:0] STAT_SYSMIN = 8'hF1;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;

    typedef enum logic [3:0] {
        PH_STOPPED,
        PH_DELTA,
        PH_STATUS,
        PH_META_TYPE,
        PH_META_LEN,
        PH_SKIP,
        PH_TEMPO,
        PH_SX_LEN,
        PH_SX_DATA,
        PH_ESC_LEN,
        PH_DATA1,
        PH_DATA2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHANNEL,
        KIND_SX_HEADER,
        KIND_TEMPO,
        KIND_SX_DATA
    } kind_t;

    typedef struct packed {
        logic                  command;
        logic [7:0]            data_byte;
        logic [CHUNK_BITS-1:0] track_length;
    } in_item_t;

    typedef struct packed {
        logic                  valid;
        kind_t                 kind;
        logic [MSG_BITS-1:0]   message;
        logic [SXLEN_BITS-1:0] sysex_length;
        logic [7:0]            data_value;
        logic                  last;
    } result_t;

endpackage

[rtl/smf_in_stage.sv]
// Input register of the track chunk parser: takes one item from the slave
// stream and holds it until the parser consumes it. Depends on smf_pkg.
module smf_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smf_pkg::IN_DATA_BITS-1:0] s_tdata,  // data_byte, track_length
    input  logic                            s_tuser,  // command
    input  logic                            advance_i,
    output logic                            item_valid_o,
    output smf_pkg::in_item_t               item_o
);

    logic              valid_reg;
    logic              valid_next;
    smf_pkg::in_item_t item_reg;

    assign s_tready     = !valid_reg || advance_i;
    assign item_valid_o = valid_reg;
    assign item_o       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance_i) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.command      <= s_tuser;
            item_reg.data_byte    <= s_tdata[7:0];
            item_reg.track_length <= s_tdata[smf_pkg::IN_DATA_BITS-1:8];
        end
    end

endmodule

[rtl/smf_parser.sv]
// Parse state and per-byte step logic of the track chunk parser: delta times,
// running status, meta, sysex and escape events. Depends on smf_pkg.
module smf_parser #(
    parameter int TICK_BITS = smf_pkg::TICK_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_i,
    input  smf_pkg::in_item_t     item_i,
    output smf_pkg::result_t      res_o,
    output logic [TICK_BITS-1:0]  tick_o
);

    localparam int VB = smf_pkg::VLQ_BITS;
    localparam int CB = smf_pkg::CHUNK_BITS;

    smf_pkg::phase_t       phase_reg, phase_next;
    logic [TICK_BITS-1:0]  tick_reg, tick_next;
    logic [VB-1:0]         vlq_value_reg, vlq_value_next;
    logic [2:0]            vlq_bytes_reg, vlq_bytes_next;
    logic [7:0]            run_status_reg, run_status_next;
    logic [7:0]            first_data_reg, first_data_next;
    logic [7:0]            meta_type_reg, meta_type_next;
    logic [VB-1:0]         payload_left_reg, payload_left_next;
    logic [23:0]           tempo_reg, tempo_next;
    logic [CB-1:0]         chunk_left_reg, chunk_left_next;
    logic [CB-1:0]         sx_offset_reg, sx_offset_next;

    logic [7:0]            b;
    logic [VB-1:0]         vlq_new;
    logic [2:0]            vlq_cnt;
    logic                  vlq_done;
    logic                  vlq_long;
    logic [CB-1:0]         chunk_dec;
    logic [TICK_BITS:0]    tick_sum;
    logic                  len_over;
    logic [VB-1:0]         pay_dec;
    logic [23:0]           tempo_new;
    logic                  do_data1;
    logic [3:0]            rs_hi;
    smf_pkg::result_t      res;

    always_comb begin
        b         = item_i.data_byte;
        vlq_new   = {vlq_value_reg[VB-8:0], b[6:0]};
        vlq_cnt   = vlq_bytes_reg + 3'd1;
        vlq_done  = !b[7];
        vlq_long  = (vlq_cnt >= 3'd4);
        chunk_dec = chunk_left_reg - CB'(1);
        tick_sum  = {1'b0, tick_reg} + (TICK_BITS+1)'(vlq_new);
        len_over  = ({{(CB-VB){1'b0}}, vlq_new} > chunk_dec);
        pay_dec   = payload_left_reg - VB'(1);
        tempo_new = {tempo_reg[15:0], b};
        rs_hi     = run_status_reg[7:4];
    end

    always_comb begin
        phase_next        = phase_reg;
        tick_next         = tick_reg;
        vlq_value_next    = vlq_value_reg;
        vlq_bytes_next    = vlq_bytes_reg;
        run_status_next   = run_status_reg;
        first_data_next   = first_data_reg;
        meta_type_next    = meta_type_reg;
        payload_left_next = payload_left_reg;
        tempo_next        = tempo_reg;
        chunk_left_next   = chunk_left_reg;
        sx_offset_next    = sx_offset_reg;
        res               = '0;
        do_data1          = 1'b0;

        if (step_i && item_i.command) begin
            phase_next        = smf_pkg::PH_DELTA;
            tick_next         = '0;
            vlq_value_next    = '0;
            vlq_bytes_next    = '0;
            run_status_next   = '0;
            first_data_next   = '0;
            meta_type_next    = '0;
            payload_left_next = '0;
            tempo_next        = '0;
            chunk_left_next   = item_i.track_length;
        end else if (step_i && phase_reg != smf_pkg::PH_STOPPED) begin
            if (chunk_left_reg == '0) begin
                phase_next = smf_pkg::PH_STOPPED;
            end else begin
                chunk_left_next = chunk_dec;
                unique case (phase_reg)
                    smf_pkg::PH_DELTA: begin
                        if (vlq_done) begin
                            tick_next      = tick_sum[TICK_BITS] ? {TICK_BITS{1'b1}}
                                                                 : tick_sum[TICK_BITS-1:0];
                            vlq_value_next = '0;
                            vlq_bytes_next = '0;
                            phase_next     = smf_pkg::PH_STATUS;
                        end else if (vlq_long) begin
                            phase_next = smf_pkg::PH_STOPPED;
                        end else begin
                            vlq_value_next = vlq_new;
                            vlq_bytes_next = vlq_cnt;
                        end
                    end
                    smf_pkg::PH_STATUS: begin
                        if (b == smf_pkg::STAT_META) begin
                            run_status_next = '0;
                            phase_next      = smf_pkg::PH_META_TYPE;
                        end else if (b == smf_pkg::STAT_SYSEX) begin
                            run_status_next = '0;
                            phase_next      = smf_pkg::PH_SX_LEN;
                        end else if (b == smf_pkg::STAT_ESCAPE) begin
                            run_status_next = '0;
                            phase_next      = smf_pkg::PH_ESC_LEN;
                        end else if (b >= smf_pkg::STAT_SYSMIN) begin
                            phase_next = smf_pkg::PH_STOPPED;
                        end else if ((b & smf_pkg::BYTE_HIGH) != 8'h00) begin
                            run_status_next = b;
                            phase_next      = smf_pkg::PH_DATA1;
                        end else if (run_status_reg == 8'h00) begin
                            phase_next = smf_pkg::PH_STOPPED;
                        end else begin
                            do_data1 = 1'b1;
                        end
                    end
                    smf_pkg::PH_DATA1: begin
                        do_data1 = 1'b1;
                    end
                    smf_pkg::PH_DATA2: begin
                        phase_next       = smf_pkg::PH_DELTA;
                        res.valid        = 1'b1;
                        res.kind         = smf_pkg::KIND_CHANNEL;
                        res.message      = {b, first_data_reg, run_status_reg};
                        res.last         = 1'b1;
                    end
                    smf_pkg::PH_META_TYPE: begin
                        meta_type_next = b;
                        vlq_value_next = '0;
                        vlq_bytes_next = '0;
                        phase_next     = smf_pkg::PH_META_LEN;
                    end
                    smf_pkg::PH_META_LEN, smf_pkg::PH_SX_LEN, smf_pkg::PH_ESC_LEN: begin
                        if (vlq_done) begin
                            vlq_value_next = '0;
                            vlq_bytes_next = '0;
                            if (len_over) begin
                                phase_next = smf_pkg::PH_STOPPED;
                            end else begin
                                payload_left_next = vlq_new;
                                if (phase_reg == smf_pkg::PH_META_LEN) begin
                                    if (meta_type_reg == smf_pkg::META_EOT) begin
                                        phase_next = smf_pkg::PH_STOPPED;
                                    end else if (meta_type_reg == smf_pkg::META_TEMPO
                                                 && vlq_new == VB'(3)) begin
                                        tempo_next = '0;
                                        phase_next = smf_pkg::PH_TEMPO;
                                    end else begin
                                        phase_next = (vlq_new == '0) ? smf_pkg::PH_DELTA
                                                                     : smf_pkg::PH_SKIP;
                                    end
                                end else if (phase_reg == smf_pkg::PH_ESC_LEN) begin
                                    phase_next = (vlq_new == '0) ? smf_pkg::PH_DELTA
                                                                 : smf_pkg::PH_SKIP;
                                end else begin
                                    res.valid        = 1'b1;
                                    res.kind         = smf_pkg::KIND_SX_HEADER;
                                    res.message      = sx_offset_reg[smf_pkg::MSG_BITS-1:0];
                                    res.sysex_length = smf_pkg::SXLEN_BITS'(vlq_new)
                                                       + smf_pkg::SXLEN_BITS'(1);
                                    res.data_value   = smf_pkg::STAT_SYSEX;
                                    res.last         = (vlq_new == '0);
                                    sx_offset_next   = sx_offset_reg + CB'(vlq_new) + CB'(1);
                                    phase_next       = (vlq_new == '0) ? smf_pkg::PH_DELTA
                                                                       : smf_pkg::PH_SX_DATA;
                                end
                            end
                        end else if (vlq_long) begin
                            phase_next = smf_pkg::PH_STOPPED;
                        end else begin
                            vlq_value_next = vlq_new;
                            vlq_bytes_next = vlq_cnt;
                        end
                    end
                    smf_pkg::PH_SKIP: begin
                        payload_left_next = pay_dec;
                        if (pay_dec == '0) begin
                            phase_next = smf_pkg::PH_DELTA;
                        end
                    end
                    smf_pkg::PH_TEMPO: begin
                        tempo_next        = tempo_new;
                        payload_left_next = pay_dec;
                        if (pay_dec == '0) begin
                            phase_next  = smf_pkg::PH_DELTA;
                            res.valid   = 1'b1;
                            res.kind    = smf_pkg::KIND_TEMPO;
                            res.message = tempo_new;
                            res.last    = 1'b1;
                        end
                    end
                    smf_pkg::PH_SX_DATA: begin
                        payload_left_next = pay_dec;
                        res.valid         = 1'b1;
                        res.kind          = smf_pkg::KIND_SX_DATA;
                        res.data_value    = b;
                        res.last          = (pay_dec == '0);
                        if (pay_dec == '0) begin
                            phase_next = smf_pkg::PH_DELTA;
                        end
                    end
                    default: begin
                        phase_next = smf_pkg::PH_STOPPED;
                    end
                endcase

                if (do_data1) begin
                    first_data_next = b;
                    if (rs_hi == smf_pkg::HI_PROGRAM || rs_hi == smf_pkg::HI_PRESSURE) begin
                        phase_next  = smf_pkg::PH_DELTA;
                        res.valid   = 1'b1;
                        res.kind    = smf_pkg::KIND_CHANNEL;
                        res.message = {8'h00, b, run_status_reg};
                        res.last    = 1'b1;
                    end else begin
                        phase_next = smf_pkg::PH_DATA2;
                    end
                end
            end
        end
    end

    assign res_o  = res;
    assign tick_o = tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= smf_pkg::PH_STOPPED;
            tick_reg         <= '0;
            vlq_value_reg    <= '0;
            vlq_bytes_reg    <= '0;
            run_status_reg   <= '0;
            first_data_reg   <= '0;
            meta_type_reg    <= '0;
            payload_left_reg <= '0;
            tempo_reg        <= '0;
            chunk_left_reg   <= '0;
            sx_offset_reg    <= '0;
        end else begin
            phase_reg        <= phase_next;
            tick_reg         <= tick_next;
            vlq_value_reg    <= vlq_value_next;
            vlq_bytes_reg    <= vlq_bytes_next;
            run_status_reg   <= run_status_next;
            first_data_reg   <= first_data_next;
            meta_type_reg    <= meta_type_next;
            payload_left_reg <= payload_left_next;
            tempo_reg        <= tempo_next;
            chunk_left_reg   <= chunk_left_next;
            sx_offset_reg    <= sx_offset_next;
        end
    end

    a_tick_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_i && item_i.command) |=> tick_reg >= $past(tick_reg))
        else $error("tick moved back without a start item");

    a_sx_data_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.kind == smf_pkg::KIND_SX_DATA |-> phase_reg == smf_pkg::PH_SX_DATA)
        else $error("sysex byte emitted outside sysex payload");

    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == smf_pkg::PH_STOPPED && !(step_i && item_i.command)
        |=> phase_reg == smf_pkg::PH_STOPPED && chunk_left_reg == $past(chunk_left_reg))
        else $error("parser left stop without a start item");

    a_vlq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i |=> vlq_bytes_reg <= 3'd3)
        else $error("delta or length field exceeded four bytes");

endmodule

[rtl/smf_out_stage.sv]
// Result register of the track chunk parser: holds one result item for the
// master stream and packs its fields. Depends on smf_pkg.
module smf_out_stage #(
    parameter int TICK_BITS = smf_pkg::TICK_BITS_DEF,
    parameter int OUT_W     = ((2 + TICK_BITS + smf_pkg::MSG_BITS
                                + smf_pkg::SXLEN_BITS + 8 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance_i,
    input  smf_pkg::result_t      res_i,
    input  logic [TICK_BITS-1:0]  tick_i,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,  // kind, event_tick, message, sysex_length, data_value
    output logic                  m_tlast   // last
);

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] data_reg;
    logic             last_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance_i) begin
            valid_next = res_i.valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_i && res_i.valid) begin
            data_reg <= OUT_W'({res_i.data_value, res_i.sysex_length, res_i.message,
                                tick_i, res_i.kind});
            last_reg <= res_i.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

[rtl/smf_track_event_parser_top.sv]
// Track chunk parser top level. A byte is held in the input register, then the
// result it causes is registered in the result register and shown on the master side.
// Throughput: one item per cycle while the master side is not stalled; the input register and
// result register are the only stages, and the per-byte state update fits between them.
// Reset: synchronous on aresetn low; the parser stays stopped until a start item.
module smf_track_event_parser_top #(
    parameter int TICK_BITS = smf_pkg::TICK_BITS_DEF,
    parameter int OUT_W     = ((2 + TICK_BITS + smf_pkg::MSG_BITS
                                + smf_pkg::SXLEN_BITS + 8 + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [smf_pkg::IN_DATA_BITS-1:0] s_tdata,  // data_byte, track_length
    input  logic                             s_tuser,  // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata,  // kind, event_tick, message, sysex_length, data_value
    output logic                             m_tlast   // last
);

    logic                  item_valid;
    smf_pkg::in_item_t     item;
    logic                  advance;
    smf_pkg::result_t      res;
    logic [TICK_BITS-1:0]  tick;

    assign advance = item_valid && (!m_tvalid || m_tready);

    smf_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .advance_i    (advance),
        .item_valid_o (item_valid),
        .item_o       (item)
    );

    smf_parser #(.TICK_BITS(TICK_BITS)) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (advance),
        .item_i  (item),
        .res_o   (res),
        .tick_o  (tick)
    );

    smf_out_stage #(.TICK_BITS(TICK_BITS), .OUT_W(OUT_W)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance_i (advance),
        .res_i     (res),
        .tick_i    (tick),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
